>>> src/pointer_click_drag_classifier_macros.svh
// Assertion macros used by the port-level checker of the pointer classifier.
`ifndef POINTER_CLICK_DRAG_CLASSIFIER_MACROS_SVH
`define POINTER_CLICK_DRAG_CLASSIFIER_MACROS_SVH

// Concurrent assertion on clk that is switched off while rst_n is low.
`define PCDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on clk that also holds during reset.
`define PCDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/pcdc_pkg.sv
// Package with the types, constants and helper functions of the pointer classifier.
package pcdc_pkg;

    localparam int unsigned PosW  = 12;
    localparam int unsigned DeltaW = 13;
    localparam int unsigned ThrW  = 12;
    localparam int unsigned ThrSqW = 2 * ThrW;
    localparam int unsigned DataW = 64;
    localparam int unsigned ApbAddrW = 3;
    localparam int unsigned ApbDataW = 32;

    // Register index of the drag threshold (the only register).
    localparam logic [0:0] REG_DRAG_THRESHOLD = 1'b0;

    localparam logic [ThrW-1:0]   THR_RESET    = ThrW'(4);
    localparam logic [ThrSqW-1:0] THR_SQ_RESET = ThrSqW'(4 * 4);

    typedef enum logic [1:0] {
        BTN_NONE   = 2'd0,
        BTN_LEFT   = 2'd1,
        BTN_MIDDLE = 2'd2,
        BTN_RIGHT  = 2'd3
    } btn_t;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_ORBIT = 2'd1,
        MODE_PAN   = 2'd2,
        MODE_ZOOM  = 2'd3
    } mode_t;

    // One pointer sample; the last member sits in bit 0.
    typedef struct packed {
        logic [6:0]               pad;
        logic signed [DeltaW-1:0] move_dy;
        logic signed [DeltaW-1:0] move_dx;
        logic [PosW-1:0]          pointer_y;
        logic [PosW-1:0]          pointer_x;
        logic                     focused;
        logic                     hovered;
        logic                     zoom_modifier;
        logic                     pan_modifier;
        logic                     right_down;
        logic                     middle_down;
        logic                     left_down;
    } in_item_t;

    // One classification result; the last member sits in bit 0.
    typedef struct packed {
        logic [3:0]               pad;
        logic signed [DeltaW-1:0] out_dy;
        logic signed [DeltaW-1:0] out_dx;
        logic [PosW-1:0]          click_y;
        logic [PosW-1:0]          click_x;
        btn_t                     cur_button;
        mode_t                    mode;
        logic                     click_drop;
        logic                     click_ok;
        logic                     click_wait;
        logic                     dragging;
        logic                     drag_finish;
        logic                     drag_begin;
    } out_item_t;

    // Classifier state carried from one sample to the next.
    typedef struct packed {
        logic            prev_left;
        logic            prev_middle;
        logic            prev_right;
        logic            click_pending;
        logic [PosW-1:0] press_x;
        logic [PosW-1:0] press_y;
        btn_t            drag_btn;
        mode_t           mode;
    } state_t;

    // Level of the given button in the current sample.
    function automatic logic level_of(btn_t b, logic l, logic m, logic r);
        logic lvl;
        unique case (b)
            BTN_LEFT:   lvl = l;
            BTN_MIDDLE: lvl = m;
            BTN_RIGHT:  lvl = r;
            default:    lvl = 1'b0;
        endcase
        return lvl;
    endfunction

    // Navigation mode selected by a drag button and the modifiers.
    function automatic mode_t mode_for(btn_t b, logic pan, logic zoom);
        mode_t md;
        unique case (b)
            BTN_LEFT:   md = pan ? MODE_PAN : (zoom ? MODE_ZOOM : MODE_ORBIT);
            BTN_MIDDLE: md = MODE_PAN;
            BTN_RIGHT:  md = MODE_PAN;
            default:    md = MODE_NONE;
        endcase
        return md;
    endfunction

endpackage

>>> src/pcdc_cfg.sv
// Configuration register block: drag threshold and its precomputed square.
module pcdc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcdc_pkg::ApbAddrW-1:0]  paddr,
    input  logic [pcdc_pkg::ApbDataW-1:0]  pwdata,
    output logic [pcdc_pkg::ApbDataW-1:0]  prdata,
    output logic                           pready,
    output logic [pcdc_pkg::ThrSqW-1:0]    thr_sq
);
    import pcdc_pkg::*;

    logic [ThrW-1:0]   thr_reg;
    logic [ThrSqW-1:0] thr_sq_reg;
    logic [ThrW-1:0]   thr_next;
    logic [ThrSqW-1:0] thr_sq_next;
    logic              sel_thr;
    logic              wr_en;

    // Word decode: the register index is the address above the byte offset.
    assign sel_thr = (paddr[ApbAddrW-1:2] == REG_DRAG_THRESHOLD);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // The square is formed once per write so the sample path only compares.
    assign thr_next    = pwdata[ThrW-1:0];
    assign thr_sq_next = {{ThrW{1'b0}}, thr_next} * {{ThrW{1'b0}}, thr_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THR_RESET;
            thr_sq_reg <= THR_SQ_RESET;
        end
        else if (wr_en && sel_thr)
        begin
            thr_reg    <= thr_next;
            thr_sq_reg <= thr_sq_next;
        end
    end

    // Read data: the threshold, zero elsewhere.
    assign prdata = sel_thr ? {{(ApbDataW-ThrW){1'b0}}, thr_reg} : '0;
    assign thr_sq = thr_sq_reg;

endmodule

>>> src/pcdc_core.sv
// Classifier core: state registers and the single-pass decision logic for one sample.
module pcdc_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  pcdc_pkg::in_item_t          item,
    input  logic [pcdc_pkg::ThrSqW-1:0] thr_sq,
    output pcdc_pkg::out_item_t         result
);
    import pcdc_pkg::*;

    state_t          state_reg;
    state_t          state_next;
    logic [PosW-1:0] dist_x;
    logic [PosW-1:0] dist_y;
    logic [ThrSqW-1:0] sq_x;
    logic [ThrSqW-1:0] sq_y;
    logic [ThrSqW:0] move_sq;
    logic            moved;
    logic            l_press;
    logic            m_press;
    logic            r_press;
    logic            l_rel;
    logic            started;
    btn_t            join_btn;
    btn_t            press_btn;
    btn_t            alt_a;
    btn_t            alt_b;
    btn_t            hand_btn;

    // Squared distance from the press point, compared with the squared threshold.
    assign dist_x = (item.pointer_x >= state_reg.press_x) ? item.pointer_x - state_reg.press_x
                                                          : state_reg.press_x - item.pointer_x;
    assign dist_y = (item.pointer_y >= state_reg.press_y) ? item.pointer_y - state_reg.press_y
                                                          : state_reg.press_y - item.pointer_y;
    assign sq_x    = {{PosW{1'b0}}, dist_x} * {{PosW{1'b0}}, dist_x};
    assign sq_y    = {{PosW{1'b0}}, dist_y} * {{PosW{1'b0}}, dist_y};
    assign move_sq = {1'b0, sq_x} + {1'b0, sq_y};
    assign moved   = move_sq > {1'b0, thr_sq};

    // Button edges against the previous sample.
    assign l_press = item.left_down   && !state_reg.prev_left;
    assign m_press = item.middle_down && !state_reg.prev_middle;
    assign r_press = item.right_down  && !state_reg.prev_right;
    assign l_rel   = !item.left_down  && state_reg.prev_left;

    // Next state and result for one sample, in decision order.
    always_comb
    begin
        state_next = state_reg;
        result     = '0;
        started    = 1'b0;
        join_btn   = BTN_NONE;
        press_btn  = BTN_NONE;
        alt_a      = BTN_LEFT;
        alt_b      = BTN_RIGHT;
        hand_btn   = BTN_NONE;

        if (!item.focused)
        begin
            // Losing focus cancels any drag and any pending click.
            result.drag_finish       = (state_reg.drag_btn != BTN_NONE);
            result.click_drop        = state_reg.click_pending;
            state_next.click_pending = 1'b0;
            state_next.drag_btn      = BTN_NONE;
            state_next.mode          = MODE_NONE;
        end
        else
        begin
            // A pending click turns into a drag or is decided on left release.
            if (state_reg.click_pending)
            begin
                if (item.left_down && item.right_down)
                    join_btn = BTN_RIGHT;
                else if (item.left_down && item.middle_down)
                    join_btn = BTN_MIDDLE;
                else if (item.left_down && moved)
                    join_btn = BTN_LEFT;

                if (join_btn != BTN_NONE)
                begin
                    state_next.click_pending = 1'b0;
                    state_next.drag_btn      = join_btn;
                    state_next.mode = mode_for(join_btn, item.pan_modifier, item.zoom_modifier);
                    started = 1'b1;
                end
                else if (l_rel)
                begin
                    result.click_ok          = item.hovered && !moved;
                    result.click_drop        = !(item.hovered && !moved);
                    result.click_x           = item.pointer_x;
                    result.click_y           = item.pointer_y;
                    state_next.click_pending = 1'b0;
                end
            end

            // A fresh press while idle and hovered.
            if (!state_next.click_pending && state_next.drag_btn == BTN_NONE
                && item.hovered)
            begin
                if (l_press)
                    press_btn = BTN_LEFT;
                else if (m_press)
                    press_btn = BTN_MIDDLE;
                else if (r_press)
                    press_btn = BTN_RIGHT;

                if (press_btn == BTN_LEFT && !item.pan_modifier && !item.zoom_modifier)
                begin
                    state_next.click_pending = 1'b1;
                    state_next.press_x       = item.pointer_x;
                    state_next.press_y       = item.pointer_y;
                end
                else if (press_btn != BTN_NONE)
                begin
                    state_next.drag_btn = press_btn;
                    state_next.mode = mode_for(press_btn, item.pan_modifier, item.zoom_modifier);
                    started = 1'b1;
                end
            end

            // Drag button released: hand over to another held button or end.
            if (state_next.drag_btn != BTN_NONE
                && !level_of(state_next.drag_btn, item.left_down, item.middle_down,
                             item.right_down))
            begin
                case (state_next.drag_btn)
                    BTN_LEFT:
                    begin
                        alt_a = BTN_RIGHT;
                        alt_b = BTN_MIDDLE;
                    end
                    BTN_RIGHT:
                    begin
                        alt_a = BTN_LEFT;
                        alt_b = BTN_MIDDLE;
                    end
                    default:
                    begin
                        alt_a = BTN_LEFT;
                        alt_b = BTN_RIGHT;
                    end
                endcase

                if (level_of(alt_a, item.left_down, item.middle_down, item.right_down))
                    hand_btn = alt_a;
                else if (level_of(alt_b, item.left_down, item.middle_down, item.right_down))
                    hand_btn = alt_b;

                if (hand_btn != BTN_NONE)
                begin
                    state_next.drag_btn = hand_btn;
                    state_next.mode = mode_for(hand_btn, item.pan_modifier, item.zoom_modifier);
                    started = 1'b1;
                end
                else
                begin
                    result.drag_finish  = 1'b1;
                    state_next.drag_btn = BTN_NONE;
                    state_next.mode     = MODE_NONE;
                end
            end

            result.drag_begin = started;
            result.dragging   = (state_next.drag_btn != BTN_NONE);
            result.click_wait = state_next.click_pending;
            result.mode       = state_next.mode;
            result.cur_button = state_next.drag_btn;
            result.out_dx     = started ? '0 : item.move_dx;
            result.out_dy     = started ? '0 : item.move_dy;
        end

        state_next.prev_left   = item.left_down;
        state_next.prev_middle = item.middle_down;
        state_next.prev_right  = item.right_down;
    end

    // State advances once for each sample that moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{prev_left: 1'b0, prev_middle: 1'b0, prev_right: 1'b0,
                           click_pending: 1'b0, press_x: '0, press_y: '0,
                           drag_btn: BTN_NONE, mode: MODE_NONE};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/pointer_click_drag_classifier.sv
// A sample accepted into the input register moves on to the result register when that
// register is empty or being drained. Throughput: one sample per cycle unless m_tready
// stalls; the input and result registers each hold one transaction, so a new sample is
// taken while a finished result waits. The per-sample path is two 12-bit squares, an add
// and a compare against the stored squared threshold. Reset (rst_n low, asynchronous)
// empties both registers, clears the classifier state and sets the drag threshold to 4.
module pointer_click_drag_classifier (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // left_down, middle_down, right_down, pan_modifier, zoom_modifier, hovered,
    // focused, pointer_x[18:7], pointer_y[30:19], move_dx[43:31], move_dy[56:44]
    input  logic [pcdc_pkg::DataW-1:0]     s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // drag_begin, drag_finish, dragging, click_wait, click_ok,
    // click_drop, mode[7:6], cur_button[9:8], click_x[21:10],
    // click_y[33:22], out_dx[46:34], out_dy[59:47]
    output logic [pcdc_pkg::DataW-1:0]     m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcdc_pkg::ApbAddrW-1:0]  paddr,
    input  logic [pcdc_pkg::ApbDataW-1:0]  pwdata,
    output logic [pcdc_pkg::ApbDataW-1:0]  prdata,
    output logic                           pready
);
    import pcdc_pkg::*;

    in_item_t          in_reg;
    logic              in_valid_reg;
    out_item_t         out_reg;
    logic              out_valid_reg;
    out_item_t         result;
    logic [ThrSqW-1:0] thr_sq;
    logic              advance;

    // A held sample moves on when the result register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    pcdc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thr_sq  (thr_sq)
    );

    pcdc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_reg),
        .thr_sq  (thr_sq),
        .result  (result)
    );

    // Valid flags of the two pipeline registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_reg <= in_item_t'(s_tdata);
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

>>> src/pcdc_checker.sv
// Port-level checker for the pointer classifier and its bind to the top level.
`include "pointer_click_drag_classifier_macros.svh"

module pcdc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [pcdc_pkg::DataW-1:0] m_tdata
);
    import pcdc_pkg::*;

    out_item_t res;
    logic      stalled;
    logic      start_clean;
    logic      drag_agrees;
    logic      click_agrees;

    assign res     = out_item_t'(m_tdata);
    assign stalled = m_tvalid && !m_tready;

    // A drag start always leaves a drag active and drops the motion.
    assign start_clean = res.dragging && res.out_dx == '0 && res.out_dy == '0;

    // Drag flag, button and mode agree.
    assign drag_agrees = (res.dragging == (res.cur_button != BTN_NONE))
                         && (res.dragging == (res.mode != MODE_NONE));

    // A click is never both pending and dragged, nor both released and cancelled.
    assign click_agrees = !(res.click_wait && res.dragging) && !(res.click_ok && res.click_drop);

    // A stalled result transaction holds.
    `PCDC_ASSERT(a_out_hold, stalled |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    `PCDC_ASSERT(a_start_zero, m_tvalid && res.drag_begin |-> start_clean, "bad drag start")

    `PCDC_ASSERT(a_drag_consistent, m_tvalid |-> drag_agrees, "drag flag, button and mode differ")

    `PCDC_ASSERT(a_click_exclusive, m_tvalid |-> click_agrees, "contradictory click flags")

endmodule

bind pointer_click_drag_classifier pcdc_checker u_pcdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/pointer_click_drag_classifier_test.sv
// Self-checking testbench for the pointer click and drag classifier: directed table, then random gestures.
`timescale 1ns / 1ps

module pointer_click_drag_classifier_test;
    import pcdc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 80;
    localparam logic [ApbAddrW-1:0] THR_ADDR = ApbAddrW'({REG_DRAG_THRESHOLD, 2'b00});

    // One row of the directed table; want is used only where checked is set.
    typedef struct {
        in_item_t  smp;
        logic      checked;
        out_item_t want;
    } step_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // left_down, middle_down, right_down, pan_modifier, zoom_modifier, hovered,
    // focused, pointer_x, pointer_y, move_dx, move_dy
    logic [DataW-1:0]    s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    // drag_begin, drag_finish, dragging, click_wait, click_ok,
    // click_drop, mode, cur_button, click_x, click_y, out_dx, out_dy
    logic [DataW-1:0]    m_tdata;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    // Classifier state as the testbench predicts it.
    logic            seen_left;
    logic            seen_middle;
    logic            seen_right;
    logic            click_armed;
    logic [PosW-1:0] press_x;
    logic [PosW-1:0] press_y;
    btn_t            drag_btn;
    mode_t           nav_mode;
    logic [ThrW-1:0] drag_thr;

    // Pointer walk used by the random gestures.
    logic walk_l;
    logic walk_m;
    logic walk_r;
    int   walk_x;
    int   walk_y;

    out_item_t expected_results[$];
    step_row_t directed_rows[$];

    int   cycle_count;
    int   mismatches;
    int   samples_sent;
    int   settings_used;
    int   clicks_done;
    int   clicks_dropped;
    int   drags_begun;
    int   drags_done;
    int   idle_pct;
    logic quiet;

    pointer_click_drag_classifier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    // Level of a drag button in the given sample.
    function automatic logic button_held(btn_t b, in_item_t s);
        logic held;
        case (b)
            BTN_LEFT:   held = s.left_down;
            BTN_MIDDLE: held = s.middle_down;
            BTN_RIGHT:  held = s.right_down;
            default:    held = 1'b0;
        endcase
        return held;
    endfunction

    // Navigation mode chosen by a drag button and the modifier keys.
    function automatic mode_t drag_mode(btn_t b, in_item_t s);
        mode_t md;
        case (b)
            BTN_LEFT:
            begin
                if (s.pan_modifier)
                    md = MODE_PAN;
                else if (s.zoom_modifier)
                    md = MODE_ZOOM;
                else
                    md = MODE_ORBIT;
            end
            BTN_MIDDLE, BTN_RIGHT: md = MODE_PAN;
            default:               md = MODE_NONE;
        endcase
        return md;
    endfunction

    // Predicts the result of one sample and advances the predicted state.
    function automatic out_item_t classify_sample(in_item_t s);
        out_item_t       res;
        logic            l_press;
        logic            m_press;
        logic            r_press;
        logic            l_release;
        logic            started;
        logic            ended;
        logic            c_rel;
        logic            c_can;
        logic [PosW-1:0] cx;
        logic [PosW-1:0] cy;
        longint          ex;
        longint          ey;
        longint          dist_sq;
        longint          thr_sq;
        btn_t            nb;
        btn_t            first_alt;
        btn_t            second_alt;

        res = '0;
        l_press   = s.left_down && !seen_left;
        m_press   = s.middle_down && !seen_middle;
        r_press   = s.right_down && !seen_right;
        l_release = !s.left_down && seen_left;
        started = 1'b0;
        ended   = 1'b0;
        c_rel   = 1'b0;
        c_can   = 1'b0;
        cx = '0;
        cy = '0;

        // Losing focus drops any drag or pending click.
        if (!s.focused)
        begin
            res.drag_finish = (drag_btn != BTN_NONE);
            res.click_drop  = click_armed;
            click_armed = 1'b0;
            drag_btn    = BTN_NONE;
            nav_mode    = MODE_NONE;
            seen_left   = s.left_down;
            seen_middle = s.middle_down;
            seen_right  = s.right_down;
            return res;
        end

        // A pending click becomes a drag, a click or a cancel.
        if (click_armed)
        begin
            ex = longint'(s.pointer_x) - longint'(press_x);
            ey = longint'(s.pointer_y) - longint'(press_y);
            dist_sq = ex * ex + ey * ey;
            thr_sq  = longint'(drag_thr) * longint'(drag_thr);
            nb = BTN_NONE;
            if (s.left_down && s.right_down)
                nb = BTN_RIGHT;
            else if (s.left_down && s.middle_down)
                nb = BTN_MIDDLE;
            else if (s.left_down && dist_sq > thr_sq)
                nb = BTN_LEFT;
            if (nb != BTN_NONE)
            begin
                click_armed = 1'b0;
                drag_btn    = nb;
                nav_mode    = drag_mode(nb, s);
                started     = 1'b1;
            end
            else if (l_release)
            begin
                c_rel = s.hovered && (dist_sq <= thr_sq);
                c_can = !c_rel;
                cx = s.pointer_x;
                cy = s.pointer_y;
                click_armed = 1'b0;
            end
        end

        // New presses count only when idle and hovered.
        if (!click_armed && drag_btn == BTN_NONE && s.hovered)
        begin
            if (l_press)
                nb = BTN_LEFT;
            else if (m_press)
                nb = BTN_MIDDLE;
            else if (r_press)
                nb = BTN_RIGHT;
            else
                nb = BTN_NONE;
            if (nb == BTN_LEFT && !s.pan_modifier && !s.zoom_modifier)
            begin
                click_armed = 1'b1;
                press_x = s.pointer_x;
                press_y = s.pointer_y;
            end
            else if (nb != BTN_NONE)
            begin
                drag_btn = nb;
                nav_mode = drag_mode(nb, s);
                started  = 1'b1;
            end
        end

        // Released drag button hands over to another held button or ends the drag.
        if (drag_btn != BTN_NONE && !button_held(drag_btn, s))
        begin
            case (drag_btn)
                BTN_LEFT:
                begin
                    first_alt  = BTN_RIGHT;
                    second_alt = BTN_MIDDLE;
                end
                BTN_RIGHT:
                begin
                    first_alt  = BTN_LEFT;
                    second_alt = BTN_MIDDLE;
                end
                default:
                begin
                    first_alt  = BTN_LEFT;
                    second_alt = BTN_RIGHT;
                end
            endcase
            if (button_held(first_alt, s))
                nb = first_alt;
            else if (button_held(second_alt, s))
                nb = second_alt;
            else
                nb = BTN_NONE;
            if (nb != BTN_NONE)
            begin
                drag_btn = nb;
                nav_mode = drag_mode(nb, s);
                started  = 1'b1;
            end
            else
            begin
                ended    = 1'b1;
                drag_btn = BTN_NONE;
                nav_mode = MODE_NONE;
            end
        end

        res.drag_begin  = started;
        res.drag_finish = ended;
        res.dragging    = (drag_btn != BTN_NONE);
        res.click_wait  = click_armed;
        res.click_ok    = c_rel;
        res.click_drop  = c_can;
        res.mode        = nav_mode;
        res.cur_button  = drag_btn;
        res.click_x     = cx;
        res.click_y     = cy;
        res.out_dx      = started ? '0 : s.move_dx;
        res.out_dy      = started ? '0 : s.move_dy;
        seen_left   = s.left_down;
        seen_middle = s.middle_down;
        seen_right  = s.right_down;
        return res;
    endfunction

    function automatic in_item_t sample(int l, int m, int r, int pan, int zoom, int hov,
                                        int foc, int x, int y, int dx, int dy);
        in_item_t s;
        s = '0;
        s.left_down     = l[0];
        s.middle_down   = m[0];
        s.right_down    = r[0];
        s.pan_modifier  = pan[0];
        s.zoom_modifier = zoom[0];
        s.hovered       = hov[0];
        s.focused       = foc[0];
        s.pointer_x     = PosW'(x);
        s.pointer_y     = PosW'(y);
        s.move_dx       = DeltaW'(dx);
        s.move_dy       = DeltaW'(dy);
        return s;
    endfunction

    function automatic out_item_t outcome(int st, int en, int act, int pend, int crel, int ccan,
                                          mode_t md, btn_t b, int cx, int cy, int dx, int dy);
        out_item_t o;
        o = '0;
        o.drag_begin  = st[0];
        o.drag_finish = en[0];
        o.dragging    = act[0];
        o.click_wait  = pend[0];
        o.click_ok    = crel[0];
        o.click_drop  = ccan[0];
        o.mode        = md;
        o.cur_button  = b;
        o.click_x     = PosW'(cx);
        o.click_y     = PosW'(cy);
        o.out_dx      = DeltaW'(dx);
        o.out_dy      = DeltaW'(dy);
        return o;
    endfunction

    task automatic add_row(in_item_t s);
        step_row_t row;
        row.smp     = s;
        row.checked = 1'b0;
        row.want    = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_checked(in_item_t s, out_item_t w);
        step_row_t row;
        row.smp     = s;
        row.checked = 1'b1;
        row.want    = w;
        directed_rows.push_back(row);
    endtask

    // Next step of a random pointer gesture: mostly button toggles and small moves.
    function automatic in_item_t random_sample();
        in_item_t s;
        int       reach;
        int       pick;
        s = '0;
        reach = int'($urandom_range(1, 6));
        if ($urandom_range(0, 99) < 12)
            walk_l = !walk_l;
        if ($urandom_range(0, 99) < 5)
            walk_m = !walk_m;
        if ($urandom_range(0, 99) < 5)
            walk_r = !walk_r;
        pick = int'($urandom_range(0, 99));
        if (pick < 85)
        begin
            walk_x = walk_x + int'($urandom_range(0, 2 * reach)) - reach;
            walk_y = walk_y + int'($urandom_range(0, 2 * reach)) - reach;
        end
        else if (pick < 95)
        begin
            walk_x = int'($urandom_range(0, 4095));
            walk_y = int'($urandom_range(0, 4095));
        end
        else
        begin
            walk_x = int'($urandom_range(0, 1)) * 4095;
            walk_y = int'($urandom_range(0, 1)) * 4095;
        end
        if (walk_x < 0)
            walk_x = 0;
        if (walk_x > 4095)
            walk_x = 4095;
        if (walk_y < 0)
            walk_y = 0;
        if (walk_y > 4095)
            walk_y = 4095;
        s.left_down     = walk_l;
        s.middle_down   = walk_m;
        s.right_down    = walk_r;
        s.pan_modifier  = ($urandom_range(0, 99) < 15);
        s.zoom_modifier = ($urandom_range(0, 99) < 15);
        s.hovered       = ($urandom_range(0, 99) < 90);
        s.focused       = ($urandom_range(0, 99) < 96);
        s.pointer_x     = PosW'(walk_x);
        s.pointer_y     = PosW'(walk_y);
        if ($urandom_range(0, 1) == 0)
        begin
            s.move_dx = DeltaW'($urandom);
            s.move_dy = DeltaW'($urandom);
        end
        else
        begin
            s.move_dx = DeltaW'(int'($urandom_range(0, 2 * reach)) - reach);
            s.move_dy = DeltaW'(int'($urandom_range(0, 2 * reach)) - reach);
        end
        return s;
    endfunction

    task automatic compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    // Offers one sample, waits for the transaction and records its expected result.
    task automatic send_sample(in_item_t s, logic checked, out_item_t want);
        int        gap;
        out_item_t predicted;
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            gap = int'($urandom_range(1, 11));
            @(negedge clk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = classify_sample(s);
        expected_results.push_back(checked ? want : predicted);
        samples_sent++;
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic drain_results();
        @(negedge clk) s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Writes the drag threshold over the register port and reads it back.
    task automatic write_threshold(logic [ThrW-1:0] value);
        logic [ApbDataW-1:0] readback;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THR_ADDR;
        pwdata  <= {(ApbDataW-ThrW)'($urandom), value};
        @(negedge clk) penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        drag_thr = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge clk) penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        compare_field("drag_threshold readback", 64'(value), 64'(readback[ThrW-1:0]));
        settings_used++;
    endtask

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
                     expected_results.size());
            $display("pointer_click_drag_classifier: mismatch");
            $finish;
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result transaction with nothing expected", $realtime);
            end
            else
            begin
                want = expected_results.pop_front();
                clicks_done    += int'(want.click_ok);
                clicks_dropped += int'(want.click_drop);
                drags_begun    += int'(want.drag_begin);
                drags_done     += int'(want.drag_finish);
                compare_field("drag_begin", 64'(want.drag_begin), 64'(got.drag_begin));
                compare_field("drag_finish", 64'(want.drag_finish), 64'(got.drag_finish));
                compare_field("dragging", 64'(want.dragging), 64'(got.dragging));
                compare_field("click_wait", 64'(want.click_wait), 64'(got.click_wait));
                compare_field("click_ok", 64'(want.click_ok), 64'(got.click_ok));
                compare_field("click_drop", 64'(want.click_drop), 64'(got.click_drop));
                compare_field("mode", 64'(want.mode), 64'(got.mode));
                compare_field("cur_button", 64'(want.cur_button), 64'(got.cur_button));
                compare_field("click_x", 64'(want.click_x), 64'(got.click_x));
                compare_field("click_y", 64'(want.click_y), 64'(got.click_y));
                compare_field("out_dx", 64'(want.out_dx), 64'(got.out_dx));
                compare_field("out_dy", 64'(want.out_dy), 64'(got.out_dy));
            end
        end
    end

    // Result side back-pressure: random bursts of stall and ready.
    initial
    begin
        int burst;
        wait (rst_n === 1'b1);
        forever
        begin
            burst = int'($urandom_range(1, 11));
            if (!quiet && $urandom_range(0, 99) < idle_pct)
            begin
                @(negedge clk) m_tready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
            begin
                @(negedge clk) m_tready <= 1'b1;
                repeat (burst - 1) @(negedge clk);
            end
        end
    end

    // Reset, directed table, then random gesture phases at several thresholds.
    initial
    begin
        step_row_t row;
        int        phase_thr[5];
        int        phase_idle[5];
        int        ph;
        int        i;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        seen_left   = 1'b0;
        seen_middle = 1'b0;
        seen_right  = 1'b0;
        click_armed = 1'b0;
        press_x  = '0;
        press_y  = '0;
        drag_btn = BTN_NONE;
        nav_mode = MODE_NONE;
        drag_thr = ThrW'(4);
        walk_l = 1'b0;
        walk_m = 1'b0;
        walk_r = 1'b0;
        walk_x = 2048;
        walk_y = 2048;
        cycle_count    = 0;
        mismatches     = 0;
        samples_sent   = 0;
        settings_used  = 1;
        clicks_done    = 0;
        clicks_dropped = 0;
        drags_begun    = 0;
        drags_done     = 0;
        idle_pct = 30;
        quiet    = 1'b0;

        // Unfocused right after reset: every result field is zero.
        add_checked(sample(1, 1, 1, 1, 1, 1, 0, 4095, 4095, -4096, -4096),
                    outcome(0, 0, 0, 0, 0, 0, MODE_NONE, BTN_NONE, 0, 0, 0, 0));
        // Focused with nothing pressed: motion passes through.
        add_checked(sample(0, 0, 0, 0, 0, 1, 1, 0, 0, 4095, -4096),
                    outcome(0, 0, 0, 0, 0, 0, MODE_NONE, BTN_NONE, 0, 0, 4095, -4096));
        // Plain left press arms a click.
        add_checked(sample(1, 0, 0, 0, 0, 1, 1, 100, 100, 1, 2),
                    outcome(0, 0, 0, 1, 0, 0, MODE_NONE, BTN_NONE, 0, 0, 1, 2));
        add_row(sample(1, 0, 0, 0, 0, 1, 1, 103, 102, 3, 2));
        // Release exactly at the threshold distance still completes the click.
        add_checked(sample(0, 0, 0, 0, 0, 1, 1, 104, 100, 1, -2),
                    outcome(0, 0, 0, 0, 1, 0, MODE_NONE, BTN_NONE, 104, 100, 1, -2));
        // Moving past the threshold turns the click into an orbit drag.
        add_row(sample(1, 0, 0, 0, 0, 1, 1, 200, 200, 0, 0));
        add_checked(sample(1, 0, 0, 0, 0, 1, 1, 204, 201, 4, 1),
                    outcome(1, 0, 1, 0, 0, 0, MODE_ORBIT, BTN_LEFT, 0, 0, 0, 0));
        // Right joins the drag, then takes over when left is released.
        add_row(sample(1, 0, 1, 0, 0, 1, 1, 210, 201, 6, 0));
        add_row(sample(0, 0, 1, 0, 0, 1, 1, 212, 205, 2, 4));
        add_checked(sample(0, 0, 0, 0, 0, 1, 1, 212, 205, 0, 0),
                    outcome(0, 1, 0, 0, 0, 0, MODE_NONE, BTN_NONE, 0, 0, 0, 0));
        // Middle drag; left joins and takes over in zoom mode.
        add_row(sample(0, 1, 0, 0, 0, 1, 1, 300, 300, -5, 7));
        add_row(sample(1, 1, 0, 0, 1, 1, 1, 301, 300, 1, 0));
        add_row(sample(1, 0, 0, 0, 1, 1, 1, 302, 300, 1, 0));
        add_row(sample(0, 0, 0, 0, 0, 1, 1, 302, 300, 0, 0));
        // Left with pan modifier drags at once; losing focus ends it.
        add_row(sample(1, 0, 0, 1, 0, 1, 1, 400, 10, 0, 0));
        add_checked(sample(1, 0, 0, 1, 0, 1, 0, 400, 10, 9, 9),
                    outcome(0, 1, 0, 0, 0, 0, MODE_NONE, BTN_NONE, 0, 0, 0, 0));
        // Left still held on refocus is not a new press.
        add_row(sample(1, 0, 0, 0, 0, 1, 1, 400, 10, 0, 0));
        add_row(sample(0, 0, 0, 0, 0, 1, 1, 400, 10, 0, 0));
        // Left and middle together: left arms a click, then middle joins into a drag.
        add_row(sample(1, 1, 0, 0, 0, 1, 1, 50, 60, 0, 0));
        add_row(sample(1, 1, 0, 0, 0, 1, 1, 50, 60, 0, 0));
        add_row(sample(0, 0, 0, 0, 0, 1, 1, 50, 60, 0, 0));
        // Click at the far corner; right joining together with middle wins.
        add_row(sample(1, 0, 0, 0, 0, 1, 1, 4095, 4095, 0, 0));
        add_row(sample(1, 1, 1, 0, 0, 1, 1, 4095, 4095, 0, 0));
        add_row(sample(0, 0, 0, 0, 0, 1, 1, 4095, 4095, 0, 0));
        // Release while not hovered cancels the click.
        add_row(sample(1, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
        add_checked(sample(0, 0, 0, 0, 0, 0, 1, 2, 1, 2, 1),
                    outcome(0, 0, 0, 0, 0, 1, MODE_NONE, BTN_NONE, 2, 1, 2, 1));
        // Release beyond the threshold cancels the click.
        add_row(sample(1, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
        add_checked(sample(0, 0, 0, 0, 0, 1, 1, 3, 3, 3, 3),
                    outcome(0, 0, 0, 0, 0, 1, MODE_NONE, BTN_NONE, 3, 3, 3, 3));
        // Losing focus with a click pending cancels it.
        add_row(sample(1, 0, 0, 0, 0, 1, 1, 10, 10, 0, 0));
        add_checked(sample(1, 0, 0, 0, 0, 1, 0, 10, 10, 0, 0),
                    outcome(0, 0, 0, 0, 0, 1, MODE_NONE, BTN_NONE, 0, 0, 0, 0));
        // Middle and right together: middle wins.
        add_row(sample(0, 1, 1, 0, 0, 1, 1, 20, 20, 0, 0));
        add_row(sample(0, 0, 0, 0, 0, 1, 1, 20, 20, 0, 0));

        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (directed_rows[n])
        begin
            row = directed_rows[n];
            send_sample(row.smp, row.checked, row.want);
        end

        // Random gestures, one threshold per phase; the last phase runs without idling.
        phase_thr  = '{0, 4095, 1, int'($urandom_range(2, 40)), 4};
        phase_idle = '{30, 50, 0, 20, 0};
        for (ph = 0; ph < 5; ph++)
        begin
            drain_results();
            write_threshold(ThrW'(phase_thr[ph]));
            idle_pct = phase_idle[ph];
            quiet    = (ph == 4);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // Hold off once mid-phase until every result is back.
                if (ph == 3 && i == PHASE_ITEMS / 2)
                    drain_results();
                send_sample(random_sample(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        $display("Covered %0d samples under %0d threshold settings.", samples_sent,
                 settings_used);
        $display("Seen: %0d clicks, %0d cancelled clicks, %0d drag starts, %0d drag ends.",
                 clicks_done, clicks_dropped, drags_begun, drags_done);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("pointer_click_drag_classifier: match");
        else
            $display("pointer_click_drag_classifier: mismatch");
        $finish;
    end

endmodule
